// File: hw/rtl/mrcs_pkg.sv
package mrcs_pkg;
  localparam int MAX_ROWS_D = 8;
  localparam int MAX_COLS_D = 8;
  localparam int VAL_W = 32;
  localparam int CFG_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [2:0]       row;
    logic [2:0]       col;
    logic             last;
  } res_t;
endpackage

// File: hw/rtl/mrcs_if.sv
interface mrcs_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] value;
  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface mrcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic               last;
  modport source(output valid, output sorted_value, output out_row, output out_col,
                 output last, input ready);
  modport sink(input valid, input sorted_value, input out_row, input out_col,
               input last, output ready);
endinterface

// File: hw/rtl/mrcs_ram.sv
module mrcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/mrcs_back.sv
// Back end: owns the matrix memory, loads elements from the queue, sorts
// rows then columns with one compare-swap over a registered read port,
// then streams the result.
module mrcs_back #(
  parameter int MAX_ROWS = mrcs_pkg::MAX_ROWS_D,
  parameter int MAX_COLS = mrcs_pkg::MAX_COLS_D
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic [3:0]           rows,
  input  logic [3:0]           cols,
  input  logic                 q_valid,
  input  logic [31:0]          q_data,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mrcs_pkg::res_t       res
);
  import mrcs_pkg::*;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_LOAD = 3'd0, S_RDA = 3'd1, S_RDB = 3'd2, S_CMP = 3'd3,
                         S_OUTR = 3'd4, S_OUTW = 3'd5, S_WRB = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [6:0]  cnt_r;
  logic        phase_r;  // 0 rows, 1 columns
  logic [3:0]  line_r, pos_r, pass_r;
  logic [2:0]  orow_r, ocol_r;
  logic [31:0] a_r, b_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [6:0]  total;
  logic [3:0]  len, nlines;
  logic [7:0]  addr_a, addr_b, addr_o;

  assign total = 7'(rows * cols);
  assign len = phase_r ? rows : cols;
  assign nlines = phase_r ? cols : rows;
  // bubble pair positions within the current line
  assign addr_a = phase_r ? 8'(pos_r * cols + line_r) : 8'(line_r * cols + pos_r);
  assign addr_b = phase_r ? 8'(addr_a + cols) : 8'(addr_a + 8'd1);
  assign addr_o = 8'(orow_r * cols + ocol_r);

  mrcs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  logic swap;
  assign swap = $signed(a_r) > $signed(rdata);

  always_comb begin
    we = 1'b0; waddr = cnt_r[AW-1:0]; wdata = q_data;
    raddr = addr_a[AW-1:0];
    q_pop = 1'b0;
    st_nxt = st_r;
    unique case (st_r)
      S_LOAD: begin
        q_pop = q_valid;
        we = q_valid;
      end
      S_RDA: raddr = addr_a[AW-1:0];
      S_RDB: raddr = addr_b[AW-1:0];
      S_CMP: begin
        raddr = addr_b[AW-1:0];
        we = swap; waddr = addr_a[AW-1:0]; wdata = rdata;
      end
      S_WRB: begin
        we = 1'b1; waddr = addr_b[AW-1:0]; wdata = a_r;
      end
      S_OUTR, S_OUTW: raddr = addr_o[AW-1:0];
      default: ;
    endcase
  end

  assign res_valid = (st_r == S_OUTW);
  assign res.value = rdata;
  assign res.row = orow_r;
  assign res.col = ocol_r;
  assign res.last = ({1'b0, orow_r} == rows - 4'd1) && ({1'b0, ocol_r} == cols - 4'd1);

  // sequence load, bubble passes per line, then output
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      st_r <= S_LOAD; cnt_r <= '0;
    end else begin
      unique case (st_r)
        S_LOAD: if (q_valid) begin
          if (cnt_r + 7'd1 == total) begin
            cnt_r <= '0; line_r <= '0; pos_r <= '0; pass_r <= '0;
            phase_r <= (cols == 4'd1);
            st_r <= (cols == 4'd1 && rows == 4'd1) ? S_OUTR : S_RDA;
            orow_r <= '0; ocol_r <= '0;
          end else cnt_r <= cnt_r + 7'd1;
        end
        S_RDA: st_r <= S_RDB;
        S_RDB: begin a_r <= rdata; st_r <= S_CMP; end
        S_CMP, S_WRB: begin
          if (st_r == S_CMP && swap) st_r <= S_WRB;
          else begin
            if (pos_r + 4'd2 < len - pass_r) begin
              pos_r <= pos_r + 4'd1;
              st_r <= S_RDA;
            end else begin
              pos_r <= '0;
              if (pass_r + 4'd2 < len) begin
                pass_r <= pass_r + 4'd1;
                st_r <= S_RDA;
              end else begin
                pass_r <= '0;
                if (line_r + 4'd1 < nlines) begin
                  line_r <= line_r + 4'd1;
                  st_r <= S_RDA;
                end else begin
                  line_r <= '0;
                  if (!phase_r && rows != 4'd1) begin
                    phase_r <= 1'b1;
                    st_r <= S_RDA;
                  end else st_r <= S_OUTR;
                end
              end
            end
          end
        end
        S_OUTR: st_r <= S_OUTW;
        S_OUTW: if (res_ready) begin
          if ({1'b0, ocol_r} + 4'd1 < cols) begin
            ocol_r <= ocol_r + 3'd1;
            st_r <= S_OUTR;
          end else begin
            ocol_r <= '0;
            if ({1'b0, orow_r} + 4'd1 < rows) begin
              orow_r <= orow_r + 3'd1;
              st_r <= S_OUTR;
            end else st_r <= S_LOAD;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end
endmodule

// File: hw/rtl/mrcs_front.sv
// Front end: accepts input transactions, holds the size registers and a
// small queue toward the back end.
module mrcs_front #(
  parameter int MAX_ROWS = mrcs_pkg::MAX_ROWS_D,
  parameter int MAX_COLS = mrcs_pkg::MAX_COLS_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mrcs_in_if.sink                      in_ch,
  input  logic                         cfg_we,
  input  logic [mrcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrcs_pkg::CFG_W-1:0]   cfg_data,
  output logic                         clr,
  output logic [3:0]                   rows,
  output logic [3:0]                   cols,
  output logic                         q_valid,
  output logic [31:0]                  q_data,
  input  logic                         q_pop
);
  import mrcs_pkg::*;
  logic [3:0] row_r, col_r;
  logic [31:0] q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       push;

  assign clr = cfg_we;
  // clamp sizes into the supported range
  assign rows = (row_r == 4'd0) ? 4'd1 : (row_r > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : row_r;
  assign cols = (col_r == 4'd0) ? 4'd1 : (col_r > 4'(MAX_COLS)) ? 4'(MAX_COLS) : col_r;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 4'd8; col_r <= 4'd8;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROW_COUNT) row_r <= cfg_data;
      if (cfg_index == REG_COL_COUNT) col_r <= cfg_data;
    end
  end

  // two-entry queue
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_ch.value;
    if (!rst_n || cfg_we) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// File: hw/rtl/matrix_row_then_column_sort.sv
// Loading takes one element per cycle while the two-entry queue, which registers each
// input transaction, holds data; the sort runs rows*cols*(rows+cols-2)/2 compare-swaps
// over one memory port, each through states S_RDA, S_RDB and S_CMP, plus S_WRB when a
// swap is written back; output reads each element in S_OUTR and holds it in S_OUTW until taken;
// the input stalls once the two-entry queue fills during sort and output.
// Synchronous active-low reset restores sizes 8 by 8 and an empty load.
module matrix_row_then_column_sort #(
  parameter int MAX_ROWS = mrcs_pkg::MAX_ROWS_D,
  parameter int MAX_COLS = mrcs_pkg::MAX_COLS_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mrcs_in_if.sink                        in_ch,
  mrcs_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [mrcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrcs_pkg::CFG_W-1:0]     cfg_data
);
  import mrcs_pkg::*;
  logic clr, q_valid, q_pop;
  logic [3:0] rows, cols;
  logic [31:0] q_data;
  res_t res;

  mrcs_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .clr(clr), .rows(rows), .cols(cols), .q_valid(q_valid),
    .q_data(q_data), .q_pop(q_pop));

  mrcs_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk(clk), .rst_n(rst_n), .clr(clr), .rows(rows), .cols(cols), .q_valid(q_valid),
    .q_data(q_data), .q_pop(q_pop), .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res(res));

  assign out_ch.sorted_value = res.value;
  assign out_ch.out_row = res.row;
  assign out_ch.out_col = res.col;
  assign out_ch.last = res.last;
endmodule
